// ===== rtl/utf8_to_ucs2_stream_decoder_unit_defines.svh =====
// assertion macros for the utf8 to ucs2 stream decoder checker
// no dependencies; included by the checker file
`ifndef UTF8_TO_UCS2_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UCS2_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U2U_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("u2u check failed");

// next-cycle implication, disabled during reset
`define U2U_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("u2u check failed");

`endif

// ===== rtl/u2u_pkg.sv =====
// shared types and constants for the utf8 to ucs2 stream decoder
// no dependencies
package u2u_pkg;

  // most results one input byte can cause
  localparam int MaxRes = 6;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] LeadLow   = 8'hC0;
  localparam logic [7:0] LeadHigh  = 8'hFE;
  localparam logic [7:0] Mask2     = 8'hE0;
  localparam logic [7:0] Tag2      = 8'hC0;
  localparam logic [7:0] Mask3     = 8'hF0;
  localparam logic [7:0] Tag3      = 8'hE0;
  localparam logic [7:0] Mask4     = 8'hF8;
  localparam logic [7:0] Tag4      = 8'hF0;
  localparam logic [7:0] Mask5     = 8'hFC;
  localparam logic [7:0] Tag5      = 8'hF8;
  localparam logic [7:0] PayMask   = 8'h3F;
  localparam logic [7:0] Pay2Mask  = 8'h1F;
  localparam logic [7:0] Pay3Mask  = 8'h0F;
  localparam logic [7:0] Pay4Mask  = 8'h07;
  localparam logic [7:0] Pay5Mask  = 8'h03;
  localparam logic [7:0] Pay6Mask  = 8'h01;

  // one result item
  typedef struct packed {
    logic [15:0] code;
    logic [2:0]  cnt;
    logic        eos;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    res_t [MaxRes-1:0] ent;
    logic [2:0]        n;
  } run_t;

endpackage

// ===== rtl/u2u_decode.sv =====
// sequence state and per-byte decode into a run of results
// depends on u2u_pkg
module u2u_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic [7:0]        in_byte,
  output u2u_pkg::run_t     run
);

  logic [7:0]  lead_r, lead_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  cbuf_r [4];
  logic        cbuf_wr;

  logic        is_cont;
  logic        is_lead;
  logic [15:0] acc_ext;
  logic [2:0]  nrep;
  logic        tail_on;
  u2u_pkg::res_t tail;

  // decode the byte against the open sequence
  always_comb begin
    is_cont = (in_byte & u2u_pkg::ContMask) == u2u_pkg::ContTag;
    is_lead = (in_byte >= u2u_pkg::LeadLow) && (in_byte < u2u_pkg::LeadHigh);
    acc_ext = {acc_r[9:0], in_byte[5:0] & u2u_pkg::PayMask[5:0]};
    lead_nxt = lead_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    cbuf_wr  = 1'b0;
    run      = '0;
    nrep     = '0;
    tail_on  = 1'b0;
    tail     = '0;

    if (len_r != 3'd0 && is_cont) begin
      if (({1'b0, cnt_r} + 4'd2) >= {1'b0, len_r}) begin
        // sequence complete
        run.ent[0].code = acc_ext;
        run.ent[0].cnt  = len_r;
        run.ent[0].eos  = 1'b0;
        run.n    = 3'd1;
        lead_nxt = '0;
        len_nxt  = '0;
        cnt_nxt  = '0;
        acc_nxt  = '0;
      end else begin
        cbuf_wr = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        acc_nxt = acc_ext;
      end
    end else begin
      // replay of a broken sequence, lead first
      nrep = (len_r != 3'd0) ? (cnt_r + 3'd1) : 3'd0;

      // result of the byte itself
      if (in_byte == 8'h00) begin
        tail_on   = 1'b1;
        tail.code = '0;
        tail.cnt  = 3'd0;
        tail.eos  = 1'b1;
      end else if (!is_lead) begin
        tail_on   = 1'b1;
        tail.code = {8'h00, in_byte};
        tail.cnt  = 3'd1;
        tail.eos  = 1'b0;
      end

      for (int k = 0; k < u2u_pkg::MaxRes; k++) begin
        if (3'(k) < nrep) begin
          run.ent[k].code = (k == 0) ? {8'h00, lead_r} : {8'h00, cbuf_r[2'(k + 3)]};
          run.ent[k].cnt  = 3'd1;
          run.ent[k].eos  = 1'b0;
        end else if (3'(k) == nrep && tail_on) begin
          run.ent[k] = tail;
        end
      end
      run.n = nrep + {2'b00, tail_on};

      lead_nxt = '0;
      len_nxt  = '0;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      if (is_lead) begin
        lead_nxt = in_byte;
        if ((in_byte & u2u_pkg::Mask2) == u2u_pkg::Tag2) begin
          len_nxt = 3'd2;
          acc_nxt = {8'h00, in_byte & u2u_pkg::Pay2Mask};
        end else if ((in_byte & u2u_pkg::Mask3) == u2u_pkg::Tag3) begin
          len_nxt = 3'd3;
          acc_nxt = {8'h00, in_byte & u2u_pkg::Pay3Mask};
        end else if ((in_byte & u2u_pkg::Mask4) == u2u_pkg::Tag4) begin
          len_nxt = 3'd4;
          acc_nxt = {8'h00, in_byte & u2u_pkg::Pay4Mask};
        end else if ((in_byte & u2u_pkg::Mask5) == u2u_pkg::Tag5) begin
          len_nxt = 3'd5;
          acc_nxt = {8'h00, in_byte & u2u_pkg::Pay5Mask};
        end else begin
          len_nxt = 3'd6;
          acc_nxt = {8'h00, in_byte & u2u_pkg::Pay6Mask};
        end
      end
    end
  end

  // sequence state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      len_r  <= '0;
      cnt_r  <= '0;
      acc_r  <= '0;
    end else if (in_take) begin
      lead_r <= lead_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // continuation buffer for replay
  always_ff @(posedge clk) begin
    if (in_take && cbuf_wr) begin
      cbuf_r[cnt_r[1:0]] <= in_byte;
    end
  end

endmodule

// ===== rtl/u2u_emit.sv =====
// result register holding one run and stepping through it
// depends on u2u_pkg
module u2u_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  u2u_pkg::run_t     run,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_char_code,
  output logic [2:0]        out_byte_count,
  output logic              out_end_of_string,
  output logic              out_last_of_run
);

  u2u_pkg::run_t run_r;
  logic          valid_r;
  logic [2:0]    idx_r;
  logic          take;
  logic          last;
  u2u_pkg::res_t cur;

  // current entry and handshake
  always_comb begin
    cur  = run_r.ent[idx_r];
    take = valid_r && !out_stall;
    last = idx_r == (run_r.n - 3'd1);
    free = !valid_r || (take && last);
  end

  assign out_valid         = valid_r;
  assign out_char_code     = cur.code;
  assign out_byte_count    = cur.cnt;
  assign out_end_of_string = cur.eos;
  assign out_last_of_run   = last;

  // run sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run;
    end
  end

endmodule

// ===== rtl/utf8_to_ucs2_stream_decoder_unit.sv =====
// utf8 to ucs2 stream decoder, top level
// a result is registered: it appears in the cycle after the byte that causes it is transferred
// throughput: 1 byte per cycle while the run register is free; a byte causing n results holds the input
// until the run register, which sends one result per cycle while out_stall is low, sends its last one
// reset: synchronous active-low rst_n clears the sequence state and the run register
// depends on u2u_pkg, u2u_decode, u2u_emit
module utf8_to_ucs2_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_char_code,
  output logic [2:0]  out_byte_count,
  output logic        out_end_of_string,
  output logic        out_last_of_run
);

  logic          in_take;
  logic          free;
  logic          load;
  u2u_pkg::run_t run;

  // input transfer and run load
  assign in_stall = !free;
  assign in_take  = in_valid && free;
  assign load     = in_take && (run.n != 3'd0);

  u2u_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_byte (in_byte),
    .run     (run)
  );

  u2u_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .run               (run),
    .free              (free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_code     (out_char_code),
    .out_byte_count    (out_byte_count),
    .out_end_of_string (out_end_of_string),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

// ===== rtl/u2u_checker.sv =====
// port-level checks for the utf8 to ucs2 stream decoder, bound to the top level
// depends on utf8_to_ucs2_stream_decoder_unit_defines.svh
`include "utf8_to_ucs2_stream_decoder_unit_defines.svh"

module u2u_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_char_code,
  input logic [2:0]  out_byte_count,
  input logic        out_end_of_string,
  input logic        out_last_of_run
);

  // stalled result holds
  `U2U_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable({out_char_code, out_byte_count, out_end_of_string, out_last_of_run}))

  // terminator carries code zero and count zero and closes its run
  `U2U_ASSERT_NOW(a_eos_shape, clk, rst_n, out_valid && out_end_of_string,
    out_char_code == 16'h0000 && out_byte_count == 3'd0 && out_last_of_run)

  // every other result consumed at least one byte
  `U2U_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid && !out_end_of_string,
    out_byte_count != 3'd0)

  // input waits while a run is still being sent
  `U2U_ASSERT_NOW(a_run_blocks_input, clk, rst_n, out_valid && !out_last_of_run, in_stall)

  // replayed bytes fit in one byte
  `U2U_ASSERT_NOW(a_single_byte_code, clk, rst_n, out_valid && out_byte_count == 3'd1,
    out_char_code[15:8] == 8'h00)

endmodule

bind utf8_to_ucs2_stream_decoder_unit u2u_checker u_u2u_checker (.*);

// ===== sim/u2u_stream_checker.sv =====
// checker for the utf8 to ucs2 stream decoder: decodes every byte transfer on its own
// and compares each result transfer with the oldest decoded unit; depends on u2u_pkg
`timescale 1ns / 100ps

module u2u_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_char_code,
  input  logic [2:0]  out_byte_count,
  input  logic        out_end_of_string,
  input  logic        out_last_of_run,
  output int          fail_cnt,
  output int          pending_cnt
);

  typedef struct packed {
    logic [15:0] code;
    logic [2:0]  cnt;
    logic        eos;
    logic        last;
  } unit_t;

  // decoded units still waiting for their result transfer
  unit_t expected_units[$];

  // decoder state
  logic [7:0]  lead_q;
  logic [2:0]  seq_len;
  logic [2:0]  cont_cnt;
  logic [15:0] code_acc;
  logic [7:0]  cont_buf [4];

  // decode one byte and queue the units it causes
  task automatic decode_utf8_byte(input logic [7:0] b);
    unit_t run_units [u2u_pkg::MaxRes];
    int    n;
    int    i;
    n = 0;
    if (seq_len != 0) begin
      if ((b & u2u_pkg::ContMask) == u2u_pkg::ContTag) begin
        code_acc = {code_acc[9:0], b[5:0]};
        if (int'(cont_cnt) + 2 >= int'(seq_len)) begin
          expected_units.push_back({code_acc, seq_len, 1'b0, 1'b1});
          lead_q   = '0;
          seq_len  = '0;
          cont_cnt = '0;
          code_acc = '0;
        end else begin
          cont_buf[cont_cnt[1:0]] = b;
          cont_cnt = cont_cnt + 3'd1;
        end
        return;
      end
      // broken sequence: replay lead and buffered continuations
      run_units[n] = {8'h00, lead_q, 3'd1, 1'b0, 1'b0};
      n++;
      for (i = 0; i < int'(cont_cnt) && i < 4; i++) begin
        run_units[n] = {8'h00, cont_buf[i], 3'd1, 1'b0, 1'b0};
        n++;
      end
      lead_q   = '0;
      seq_len  = '0;
      cont_cnt = '0;
      code_acc = '0;
    end
    // byte taken as fresh
    if (b == 8'h00) begin
      run_units[n] = {16'h0000, 3'd0, 1'b1, 1'b0};
      n++;
    end else if (b >= u2u_pkg::LeadLow && b < u2u_pkg::LeadHigh) begin
      lead_q   = b;
      cont_cnt = '0;
      if ((b & u2u_pkg::Mask2) == u2u_pkg::Tag2) begin
        seq_len  = 3'd2;
        code_acc = {8'h00, b & u2u_pkg::Pay2Mask};
      end else if ((b & u2u_pkg::Mask3) == u2u_pkg::Tag3) begin
        seq_len  = 3'd3;
        code_acc = {8'h00, b & u2u_pkg::Pay3Mask};
      end else if ((b & u2u_pkg::Mask4) == u2u_pkg::Tag4) begin
        seq_len  = 3'd4;
        code_acc = {8'h00, b & u2u_pkg::Pay4Mask};
      end else if ((b & u2u_pkg::Mask5) == u2u_pkg::Tag5) begin
        seq_len  = 3'd5;
        code_acc = {8'h00, b & u2u_pkg::Pay5Mask};
      end else begin
        seq_len  = 3'd6;
        code_acc = {8'h00, b & u2u_pkg::Pay6Mask};
      end
    end else begin
      run_units[n] = {8'h00, b, 3'd1, 1'b0, 1'b0};
      n++;
    end
    if (n > 0) run_units[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_units.push_back(run_units[i]);
  endtask

  // result check first, since a result never comes from the byte of the same edge
  always @(posedge clk) begin
    unit_t want;
    if (!rst_n) begin
      lead_q   = '0;
      seq_len  = '0;
      cont_cnt = '0;
      code_acc = '0;
      expected_units.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_units.size() == 0) begin
          $display("%0t: result transfer with nothing expected, code %h count %0d eos %b last %b",
                   $time, out_char_code, out_byte_count, out_end_of_string, out_last_of_run);
          fail_cnt++;
        end else begin
          want = expected_units.pop_front();
          if (out_char_code !== want.code) begin
            $display("%0t: char_code expected %h actual %h", $time, want.code, out_char_code);
            fail_cnt++;
          end
          if (out_byte_count !== want.cnt) begin
            $display("%0t: byte_count expected %0d actual %0d", $time, want.cnt,
                     out_byte_count);
            fail_cnt++;
          end
          if (out_end_of_string !== want.eos) begin
            $display("%0t: end_of_string expected %b actual %b", $time, want.eos,
                     out_end_of_string);
            fail_cnt++;
          end
          if (out_last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                     out_last_of_run);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) decode_utf8_byte(in_byte);
      pending_cnt = expected_units.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// top of the utf8 to ucs2 stream decoder testbench: clock, reset, byte stimulus,
// result-side stall and verdict; depends on the decoder unit and u2u_stream_checker
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit = 200000;
  localparam int RandBytes  = 300;
  localparam int HoldCycles = 80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_char_code;
  logic [2:0]  out_byte_count;
  logic        out_end_of_string;
  logic        out_last_of_run;

  int   fail_cnt;
  int   pending_cnt;
  int   cycle_cnt;
  int   sent_cnt;
  logic in_took;
  logic calm;
  logic hold_req;

  utf8_to_ucs2_stream_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_code     (out_char_code),
    .out_byte_count    (out_byte_count),
    .out_end_of_string (out_end_of_string),
    .out_last_of_run   (out_last_of_run)
  );

  u2u_stream_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_code     (out_char_code),
    .out_byte_count    (out_byte_count),
    .out_end_of_string (out_end_of_string),
    .out_last_of_run   (out_last_of_run),
    .fail_cnt          (fail_cnt),
    .pending_cnt       (pending_cnt)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // byte transfer seen at the rising edge, used by the driver at the falling edge
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall, calm stretch, and one long hold-off on request
  initial begin
    logic hold_used;
    out_stall = 1'b0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = rst_n && !calm && ($urandom_range(99) < 24);
      end
    end
  end

  // offer one byte, called at a falling edge, returns at the falling edge after its transfer
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    @(negedge clk);
    while (!in_took) @(negedge clk);
    sent_cnt++;
  endtask

  // one random run: mostly well-formed sequences, some broken ones, some noise
  task automatic send_random_run();
    int          kind;
    int          len;
    int          bad_pos;
    int          k;
    logic [7:0]  lead;
    logic [7:0]  b;
    kind = $urandom_range(99);
    if (kind < 12) begin
      b = 8'($urandom_range(255));
      send_byte(b);
    end else if (kind < 17) begin
      send_byte(8'h00);
    end else if (kind < 30) begin
      b = 8'($urandom_range(1, 127));
      send_byte(b);
    end else begin
      len = $urandom_range(2, 6);
      case (len)
        2: lead = 8'hC0 + 8'($urandom_range(31));
        3: lead = 8'hE0 + 8'($urandom_range(15));
        4: lead = 8'hF0 + 8'($urandom_range(7));
        5: lead = 8'hF8 + 8'($urandom_range(3));
        default: lead = 8'hFC + 8'($urandom_range(1));
      endcase
      bad_pos = ($urandom_range(99) < 20) ? $urandom_range(1, len - 1) : 0;
      send_byte(lead);
      for (k = 1; k < len; k++) begin
        if (k == bad_pos) begin
          b = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
          send_byte(b);
          break;
        end
        b = 8'h80 + 8'($urandom_range(63));
        send_byte(b);
      end
    end
  endtask

  // main stimulus and verdict
  initial begin
    logic [7:0] directed [25];
    int         i;
    logic       hold_done;
    logic       pause_done;
    directed = '{
      // terminator while idle, ascii top, idle continuation, the two pass-through bytes
      8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF,
      // two and three byte sequences
      8'hC3, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
      // six byte sequence with all payload bits set
      8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
      // bad continuation
      8'hE2, 8'h82, 8'h41,
      // zero inside a sequence, full replay then terminator
      8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00
    };
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    calm       = 1'b0;
    hold_req   = 1'b0;
    sent_cnt   = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (i = 0; i < 25; i++) send_byte(directed[i]);

    while (sent_cnt < 25 + RandBytes) begin
      // receiver holds off while bytes keep coming
      if (!hold_done && sent_cnt >= 80) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // sender waits for every pending result
      if (!pause_done && sent_cnt >= 160) begin
        in_valid = 1'b0;
        while (pending_cnt != 0) @(negedge clk);
        pause_done = 1'b1;
      end
      calm = (sent_cnt >= 200 && sent_cnt < 260);
      send_random_run();
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    // drain, then keep waiting for stray transfers before the verdict
    while (pending_cnt != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
